>>> hw/rtl/ssn_pkg.sv
package ssn_pkg;

    // Sizes of the phase, the count and the generator
    localparam int PHASE_BITS   = 24;
    localparam int SINE_ENTRIES = 256;
    localparam int COUNT_W      = 32;
    localparam int GEN_W        = 64;
    localparam int HALF_W       = GEN_W / 2;

    // Phase step: round(0.035 * 2^PHASE_BITS)
    localparam longint unsigned PHASE_STEP_L =
        (64'd35 * (64'd1 << PHASE_BITS) + 64'd500) / 64'd1000;
    localparam logic [PHASE_BITS-1:0] PHASE_STEP = PHASE_STEP_L[PHASE_BITS-1:0];

    // Quarter-wave lookup geometry
    localparam int QUAD_BITS  = PHASE_BITS - 2;
    localparam int IDX_W      = $clog2(SINE_ENTRIES + 1);
    localparam int IDX_PROD_W = QUAD_BITS + IDX_W;
    localparam int RAMP_SHIFT = 33 - PHASE_BITS;

    // xorshift64* multiplier, split into 32-bit halves
    localparam logic [GEN_W-1:0]  XS_MULT    = 64'd2685821657736338717;
    localparam logic [HALF_W-1:0] XS_MULT_LO = XS_MULT[HALF_W-1:0];
    localparam logic [HALF_W-1:0] XS_MULT_HI = XS_MULT[GEN_W-1:HALF_W];

    // Configuration
    localparam int NOISE_W     = 12;
    localparam int NOISE10_W   = 15;
    localparam int CFG_INDEX_W = 2;
    localparam logic [NOISE_W-1:0]     NOISE_MAX       = 12'd2560;
    localparam logic [CFG_INDEX_W-1:0] REG_NOISE_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED_VALUE  = 2'd1;

    // Output widths
    localparam int VALUE_W  = 17;
    localparam int JITTER_W = 16;
    localparam int SINE_W   = 17;
    localparam int BASE_W   = 42;
    localparam int JPROD_W  = 48;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // One queued sample: updated phase, count and generator state
    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [COUNT_W-1:0]    count;
        logic [GEN_W-1:0]      gen;
    } item_t;

    // Quarter-wave sine table, Q15, built at elaboration
    typedef logic [15:0] sine_tab_t [0:SINE_ENTRIES];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Taylor term n of the sine series: divide by (2n)(2n+1)
    function automatic longint unsigned taylor_div(input longint unsigned v, input int n);
        case (n)
            1:       return v / 64'd6;
            2:       return v / 64'd20;
            3:       return v / 64'd42;
            4:       return v / 64'd72;
            5:       return v / 64'd110;
            6:       return v / 64'd156;
            7:       return v / 64'd210;
            8:       return v / 64'd272;
            9:       return v / 64'd342;
            default: return v / 64'd420;
        endcase
    endfunction

    function automatic sine_tab_t build_sine();
        sine_tab_t       tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int              k;
        int              n;
        for (k = 0; k <= SINE_ENTRIES; k++)
        begin
            x    = (HALF_PI_Q30 * longint'(k) + SINE_ENTRIES / 2) / SINE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 10; n++)
            begin
                term = taylor_div((term * x2) >> 30, n);
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            sum = (sum + 16384) >>> 15;
            if (sum > 32768)
                sum = 32768;
            tab[k] = sum[15:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    // 50 - 15 in Q32: constant part of the base wave
    localparam logic signed [BASE_W-1:0] BASE_OFFSET = 42'sd150323855360;

endpackage

>>> hw/rtl/ssn_front.sv
module ssn_front import ssn_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic                   restart,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [GEN_W-1:0]       cfg_data,
    input  logic                   queue_full,
    output logic                   push,
    output item_t                  push_item,
    output logic [NOISE_W-1:0]     noise_level
);

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [GEN_W-1:0]      gen_reg, gen_next;
    logic [GEN_W-1:0]      seed_reg;
    logic [NOISE_W-1:0]    noise_reg;
    logic [GEN_W-1:0]      xs_a, xs_b, xs_c;
    logic [GEN_W-1:0]      seed_fixed;
    logic [NOISE_W-1:0]    noise_fixed;
    logic                  accept;
    logic                  cfg_write;

    assign sample_stall = queue_full;
    assign cfg_ready    = 1'b1;
    assign accept       = sample_valid && !sample_stall;
    assign cfg_write    = cfg_valid && cfg_ready;

    // xorshift step
    assign xs_a = gen_reg ^ (gen_reg >> 12);
    assign xs_b = xs_a ^ (xs_a << 25);
    assign xs_c = xs_b ^ (xs_b >> 27);

    // Register write cleanup: zero seed becomes one, noise saturates
    assign seed_fixed  = (cfg_data == '0) ? GEN_W'(1) : cfg_data;
    assign noise_fixed = (cfg_data[NOISE_W-1:0] > NOISE_MAX) ? NOISE_MAX
                                                            : cfg_data[NOISE_W-1:0];

    // Next state of phase, count and generator
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        gen_next   = gen_reg;
        if (accept)
        begin
            if (restart)
            begin
                phase_next = '0;
                count_next = '0;
                gen_next   = seed_reg;
            end
            else
            begin
                phase_next = phase_reg + PHASE_STEP;
                count_next = count_reg + COUNT_W'(1);
                gen_next   = xs_c;
            end
        end
        if (cfg_write && cfg_index == REG_SEED_VALUE)
            gen_next = seed_fixed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            gen_reg   <= GEN_W'(1);
            seed_reg  <= GEN_W'(1);
            noise_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            gen_reg   <= gen_next;
            if (cfg_write && cfg_index == REG_SEED_VALUE)
                seed_reg <= seed_fixed;
            if (cfg_write && cfg_index == REG_NOISE_LEVEL)
                noise_reg <= noise_fixed;
        end
    end

    // Samples go to the queue; restarts stay here
    assign push            = accept && !restart;
    assign push_item.phase = phase_next;
    assign push_item.count = count_next;
    assign push_item.gen   = xs_c;
    assign noise_level     = noise_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> (phase_reg == '0 && count_reg == '0))
        else $error("restart did not clear phase and count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !restart) |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("sample count did not advance");
`endif

endmodule

>>> hw/rtl/ssn_queue.sv
module ssn_queue import ssn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item,
    output logic  full
);

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_item  = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W + 1)'(1);
        end
    end

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid) && !(push && full))
        else $error("queue underflow or overflow");
`endif

endmodule

>>> hw/rtl/ssn_back.sv
module ssn_back import ssn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  item_t                      head_item,
    output logic                       pop,
    input  logic [NOISE_W-1:0]         noise_level,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [VALUE_W-1:0]  value,
    output logic signed [JITTER_W-1:0] jitter,
    output logic [PHASE_BITS-1:0]      phase_out,
    output logic [COUNT_W-1:0]         sequence_res
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_INDEX = 5'b00010,
        ST_SINE  = 5'b00100,
        ST_BASE  = 5'b01000,
        ST_DONE  = 5'b10000
    } back_state_t;

    back_state_t state_reg, state_next;

    item_t                     item_reg;
    logic [1:0]                quad_reg;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [GEN_W-1:0]          p0_reg;
    logic [HALF_W-1:0]         p1_reg, p2_reg;
    logic signed [SINE_W-1:0]  sine_reg, sine_next;
    logic signed [HALF_W-1:0]  rr_reg, rr_next;
    logic signed [VALUE_W-1:0] base88_reg, base88_next;
    logic signed [JPROD_W-1:0] jprod_reg, jprod_next;

    logic                       result_valid_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic signed [JITTER_W-1:0] jitter_reg;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [COUNT_W-1:0]         seq_reg;

    logic [QUAD_BITS-1:0]      frac;
    logic [IDX_PROD_W-1:0]     idx_sum;
    logic [IDX_W-1:0]          idx_raw, idx_clamp;
    logic [HALF_W-1:0]         gen_top;
    logic signed [BASE_W-1:0]  sine_term, ramp_term, base_sum;
    logic [NOISE10_W-1:0]      noise10;
    logic signed [VALUE_W-1:0] jit88;
    logic                      load;

    // Table index: nearest entry, mirrored in odd quadrants
    assign frac    = item_reg.phase[QUAD_BITS-1:0];
    assign idx_sum = IDX_PROD_W'(frac) * IDX_PROD_W'(SINE_ENTRIES)
                   + (IDX_PROD_W'(1) << (QUAD_BITS - 1));
    assign idx_raw   = idx_sum[IDX_PROD_W-1:QUAD_BITS];
    assign idx_clamp = (idx_raw > IDX_W'(SINE_ENTRIES)) ? IDX_W'(SINE_ENTRIES) : idx_raw;
    assign idx_next  = item_reg.phase[PHASE_BITS-2] ? IDX_W'(SINE_ENTRIES) - idx_clamp
                                                    : idx_clamp;

    // Sine lookup, negated in the lower half cycle
    assign sine_next = quad_reg[1] ? -$signed({1'b0, SINE_TAB[idx_reg]})
                                   : $signed({1'b0, SINE_TAB[idx_reg]});

    // Top word of the scrambled generator output, recentered around zero
    assign gen_top = p0_reg[GEN_W-1:HALF_W] + p1_reg + p2_reg;
    assign rr_next = $signed({~gen_top[HALF_W-1], gen_top[HALF_W-2:0]});

    // Base wave in Q32, rounded to Q8.8
    assign sine_term   = (BASE_W'(sine_reg) * BASE_W'(35)) <<< 17;
    assign ramp_term   = $signed(BASE_W'({item_reg.phase, {RAMP_SHIFT{1'b0}}}) * BASE_W'(15));
    assign base_sum    = BASE_OFFSET + sine_term + ramp_term + (BASE_W'(1) <<< 23);
    assign base88_next = base_sum[VALUE_W+23:24];

    // Jitter product
    assign noise10    = NOISE10_W'(noise_level) * NOISE10_W'(10);
    assign jprod_next = JPROD_W'(rr_reg) * JPROD_W'($signed({1'b0, noise10}));
    assign jit88      = VALUE_W'((jprod_reg + (JPROD_W'(1) <<< 30)) >>> 31);

    assign pop  = (state_reg == ST_IDLE) && head_valid;
    assign load = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (head_valid) state_next = ST_INDEX;
            ST_INDEX: state_next = ST_SINE;
            ST_SINE:  state_next = ST_BASE;
            ST_BASE:  state_next = ST_DONE;
            ST_DONE:  if (load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    // Datapath stages
    always_ff @(posedge clk)
    begin
        if (pop)
            item_reg <= head_item;
        if (state_reg == ST_INDEX)
        begin
            quad_reg <= item_reg.phase[PHASE_BITS-1:PHASE_BITS-2];
            idx_reg  <= idx_next;
            p0_reg   <= GEN_W'(item_reg.gen[HALF_W-1:0]) * GEN_W'(XS_MULT_LO);
            p1_reg   <= item_reg.gen[GEN_W-1:HALF_W] * XS_MULT_LO;
            p2_reg   <= item_reg.gen[HALF_W-1:0] * XS_MULT_HI;
        end
        if (state_reg == ST_SINE)
        begin
            sine_reg <= sine_next;
            rr_reg   <= rr_next;
        end
        if (state_reg == ST_BASE)
        begin
            base88_reg <= base88_next;
            jprod_reg  <= jprod_next;
        end
        if (load)
        begin
            value_reg  <= base88_reg + jit88;
            jitter_reg <= jit88[JITTER_W-1:0];
            phase_reg  <= item_reg.phase;
            seq_reg    <= item_reg.count;
        end
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign jitter       = jitter_reg;
    assign phase_out    = phase_reg;
    assign sequence_res = seq_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!result_valid_reg || !result_stall))
        else $error("output register overwritten while held");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_INDEX))
        else $error("popped sample not taken into the index stage");
`endif

endmodule

>>> hw/rtl/sine_saw_noise_test_signal_generator.sv
// Channel  Direction  Handshake                  Payload
// sample   in         sample_valid/sample_stall  restart
// result   out        result_valid/result_stall  value, jitter, phase_out, sequence_res
// cfg      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// In the back end a sample passes dequeue, index and generator products, table read,
// base and jitter product, round and load before the next sample is dequeued; that
// sequencer sets the rate. A restart is handled in the front end and produces no result.
// Reset (rst_n, async low) clears phase and count, loads seed and generator with one.
// A four-entry queue lets the front end accept samples while the output is stalled.
module sine_saw_noise_test_signal_generator import ssn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_stall,
    input  logic                       restart,
    output logic                       result_valid,
    input  logic                       result_stall,
    output logic signed [VALUE_W-1:0]  value,
    output logic signed [JITTER_W-1:0] jitter,
    output logic [PHASE_BITS-1:0]      phase_out,
    output logic [COUNT_W-1:0]         sequence_res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [GEN_W-1:0]           cfg_data
);

    logic               queue_full;
    logic               push;
    item_t              push_item;
    logic               pop;
    logic               head_valid;
    item_t              head_item;
    logic [NOISE_W-1:0] noise_level;

    // Front end: accepts transactions, owns phase, count, generator and registers
    ssn_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .restart      (restart),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (queue_full),
        .push         (push),
        .push_item    (push_item),
        .noise_level  (noise_level)
    );

    // Queue between front and back
    ssn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (queue_full)
    );

    // Back end: waveform and jitter arithmetic, output register
    ssn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .pop          (pop),
        .noise_level  (noise_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .jitter       (jitter),
        .phase_out    (phase_out),
        .sequence_res (sequence_res)
    );

endmodule

>>> dv/sine_saw_noise_test_signal_generator_tb.sv
`timescale 1ns / 1ps

module sine_saw_noise_test_signal_generator_tb;
    import ssn_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 3;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_CYCLES = 2000;

    localparam int QUARTER_BITS = PHASE_BITS - 2;

    // round(0.035 * 2^24)
    localparam logic [PHASE_BITS-1:0] PHASE_INC   = 24'd587203;
    localparam logic [GEN_W-1:0]      XSHIFT_MULT = 64'd2685821657736338717;
    localparam longint unsigned       HALF_PI_FX  = 64'd1686629713;
    localparam logic [NOISE_W-1:0]    NOISE_CEIL  = 12'd2560;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic [1:0] {ROW_SAMPLE, ROW_RESTART, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  index;
        logic [GEN_W-1:0]        data;
        bit                      typed;
        logic [PHASE_BITS-1:0]   ph;
        logic [COUNT_W-1:0]      cnt;
        logic signed [JITTER_W-1:0] jit;
    } plan_row_t;

    typedef struct {
        logic signed [VALUE_W-1:0]  value;
        logic signed [JITTER_W-1:0] jitter;
        logic [PHASE_BITS-1:0]      phase;
        logic [COUNT_W-1:0]         count;
    } reading_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_stall;
    logic                       restart;
    logic                       result_valid;
    logic                       result_stall;
    logic signed [VALUE_W-1:0]  value;
    logic signed [JITTER_W-1:0] jitter;
    logic [PHASE_BITS-1:0]      phase_out;
    logic [COUNT_W-1:0]         sequence_res;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [GEN_W-1:0]           cfg_data;

    // Signal source model state and registers
    logic [GEN_W-1:0]      mdl_gen   = 64'd1;
    logic [GEN_W-1:0]      mdl_seed  = 64'd1;
    logic [PHASE_BITS-1:0] mdl_phase = '0;
    logic [COUNT_W-1:0]    mdl_count = '0;
    logic [NOISE_W-1:0]    mdl_noise = '0;
    longint                quarter_sine [0:SINE_ENTRIES];

    reading_t  readings_due [$];
    plan_row_t plan [$];

    // Hand-typed expectation of the row being offered
    bit                         cur_typed = 1'b0;
    logic [PHASE_BITS-1:0]      cur_phase;
    logic [COUNT_W-1:0]         cur_count;
    logic signed [JITTER_W-1:0] cur_jitter;

    bit calm     = 1'b0;
    bit hold_req = 1'b0;
    int failures = 0;
    int stalled_cycles = 0;

    sine_saw_noise_test_signal_generator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .restart      (restart),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .jitter       (jitter),
        .phase_out    (phase_out),
        .sequence_res (sequence_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Quarter-wave sine in Q15 by Taylor series in Q30, rounded half up
    initial
    begin : build_quarter_sine
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned den;
        longint          acc;
        for (int k = 0; k <= SINE_ENTRIES; k++)
        begin
            x    = (HALF_PI_FX * k + SINE_ENTRIES / 2) / SINE_ENTRIES;
            x2   = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 10; n++)
            begin
                den  = longint'((2 * n) * (2 * n + 1));
                term = ((term * x2) >> 30) / den;
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            acc = (acc + 16384) >>> 15;
            if (acc > 32768)
                acc = 32768;
            quarter_sine[k] = acc;
        end
    end

    // Advance the model by one sample and form the reading it produces
    function automatic reading_t next_reading();
        reading_t        r;
        longint unsigned frac;
        longint unsigned idx;
        longint          sine;
        longint          ramp;
        longint          base;
        longint          base88;
        longint          draw;
        longint          lvl;
        longint          jit88;
        longint          sum88;
        logic [GEN_W-1:0] x;
        logic [GEN_W-1:0] mixed;
        mdl_count = mdl_count + 32'd1;
        mdl_phase = mdl_phase + PHASE_INC;

        // nearest table entry, mirrored in odd quadrants, negated in the lower half
        frac = 64'(mdl_phase[QUARTER_BITS-1:0]);
        idx  = (frac * SINE_ENTRIES + (64'd1 << (QUARTER_BITS - 1))) >> QUARTER_BITS;
        if (idx > SINE_ENTRIES)
            idx = SINE_ENTRIES;
        if (mdl_phase[PHASE_BITS-2])
            idx = SINE_ENTRIES - idx;
        sine = quarter_sine[idx];
        if (mdl_phase[PHASE_BITS-1])
            sine = -sine;

        // 50 + 35*sin + 15*(2p - 1) in Q32, rounded to Q8.8
        ramp   = longint'(mdl_phase);
        base   = 64'sd214748364800 + 35 * sine * 131072
               + 15 * ((ramp <<< (33 - PHASE_BITS)) - 64'sd4294967296);
        base88 = (base + (64'sd1 <<< 23)) >>> 24;

        // xorshift64* step; top half of the product as a signed fraction
        x = mdl_gen;
        x = x ^ (x >> 12);
        x = x ^ (x << 25);
        x = x ^ (x >> 27);
        mdl_gen = x;
        mixed   = x * XSHIFT_MULT;
        draw    = longint'(mixed[GEN_W-1:HALF_W]);
        draw    = draw - 64'sd2147483648;
        lvl     = longint'(mdl_noise);
        jit88   = (draw * lvl * 10 + (64'sd1 <<< 30)) >>> 31;
        sum88   = base88 + jit88;

        r.value  = sum88[VALUE_W-1:0];
        r.jitter = jit88[JITTER_W-1:0];
        r.phase  = mdl_phase;
        r.count  = mdl_count;
        return r;
    endfunction

    task automatic compare_field(input string what, input logic signed [63:0] want,
                                 input logic signed [63:0] got);
        if (got !== want)
        begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, want, got);
        end
    endtask

    // Scoreboard: predict on each accepted transaction, check each result, watchdog
    always @(posedge clk)
    begin : scoreboard
        reading_t want;
        bit       moved;
        moved = 1'b0;
        if (result_valid === 1'b1 && result_stall == 1'b0)
        begin
            moved = 1'b1;
            if (readings_due.size() == 0)
            begin
                failures++;
                $display("%0t ns: unexpected result, value %0d phase %0d count %0d",
                         $time, value, phase_out, sequence_res);
            end
            else
            begin
                want = readings_due.pop_front();
                compare_field("value", want.value, value);
                compare_field("jitter", want.jitter, jitter);
                compare_field("phase_out", want.phase, phase_out);
                compare_field("sequence_res", want.count, sequence_res);
            end
        end
        if (cfg_valid == 1'b1 && cfg_ready === 1'b1)
        begin
            moved = 1'b1;
            case (cfg_index)
                REG_NOISE_LEVEL:
                    mdl_noise = (cfg_data[NOISE_W-1:0] > NOISE_CEIL) ?
                                NOISE_CEIL : cfg_data[NOISE_W-1:0];
                REG_SEED_VALUE:
                begin
                    mdl_seed = (cfg_data == '0) ? 64'd1 : cfg_data;
                    mdl_gen  = mdl_seed;
                end
                default: ;
            endcase
        end
        if (sample_valid == 1'b1 && sample_stall === 1'b0)
        begin
            moved = 1'b1;
            if (restart)
            begin
                mdl_gen   = mdl_seed;
                mdl_phase = '0;
                mdl_count = '0;
            end
            else
            begin
                want = next_reading();
                if (cur_typed)
                begin
                    want.phase  = cur_phase;
                    want.count  = cur_count;
                    want.jitter = cur_jitter;
                end
                readings_due.push_back(want);
            end
        end
        if (!rst_n || moved)
            stalled_cycles = 0;
        else
        begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Result side: random stall runs, one long counted hold on request
    initial
    begin : result_drain
        int run_left;
        int hold_left;
        int roll;
        result_stall = 1'b0;
        run_left     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(negedge clk);
                hold_req     = 1'b0;
                result_stall <= 1'b0;
                run_left     = 0;
            end
            else if (calm)
                result_stall <= 1'b0;
            else if (run_left > 0)
                run_left--;
            else
            begin
                roll = $urandom_range(0, 99);
                result_stall <= (roll < 35);
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    run_left = $urandom_range(0, 2);
                else if (roll < 95)
                    run_left = $urandom_range(3, 10);
                else
                    run_left = $urandom_range(15, 60);
            end
        end
    end

    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_sample(input bit rs);
        sample_valid <= 1'b1;
        restart      <= rs;
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        @(negedge clk);
    endtask

    // Leaves cfg_valid high so writes can go back to back
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [GEN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
    endtask

    // Stop offering, wait for every pending reading, then idle for the given tail
    task automatic settle(input int tail);
        sample_valid <= 1'b0;
        while (readings_due.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    initial
    begin : stimulus
        plan_row_t        row;
        bit               prev_write;
        bit               seed_first;
        bit               reseed;
        logic [GEN_W-1:0] noise_pick;
        logic [GEN_W-1:0] seed_pick;
        int               sent;
        int               phase_no;
        int               phase_len;
        int               gap;
        int               pick;

        rst_n        = 1'b0;
        sample_valid = 1'b0;
        restart      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_NOISE_LEVEL;
        cfg_data     = '0;

        // Directed table; typed rows are readable directly (noise zero, phase count)
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b1, 24'd587203, 32'd1, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b1, 24'd1174406, 32'd2, 16'sd0});
        plan.push_back('{ROW_RESTART, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_RESTART, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b1, 24'd587203, 32'd1, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_NOISE_LEVEL, 64'd2560, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        // above the ceiling: saturates
        plan.push_back('{ROW_WRITE, REG_NOISE_LEVEL, 64'hFFF, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        // only the low twelve bits count: this is zero noise
        plan.push_back('{ROW_WRITE, REG_NOISE_LEVEL, 64'hFFFF_FFFF_FFFF_F000, 1'b0,
                         24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b1, 24'd2936015, 32'd5, 16'sd0});
        // zero seed stands for one
        plan.push_back('{ROW_WRITE, REG_SEED_VALUE, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_SPARE_2, '1, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_SPARE_3, 64'h5555_5555_5555_5555, 1'b0,
                         24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_NOISE_LEVEL, 64'd1, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_SEED_VALUE, '1, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_NOISE_LEVEL, 64'd2560, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_RESTART, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_NOISE_LEVEL, 64'd0, 1'b0, 24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_WRITE, REG_SEED_VALUE, 64'h8000_0000_0000_0000, 1'b0,
                         24'd0, 32'd0, 16'sd0});
        plan.push_back('{ROW_SAMPLE, REG_NOISE_LEVEL, 64'd0, 1'b1, 24'd1174406, 32'd2, 16'sd0});

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part
        prev_write = 1'b0;
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                if (!prev_write)
                    settle(SETTLE_CYCLES);
                write_reg(row.index, row.data);
            end
            else
            begin
                if (prev_write)
                    cfg_valid <= 1'b0;
                cur_typed  = row.typed;
                cur_phase  = row.ph;
                cur_count  = row.cnt;
                cur_jitter = row.jit;
                offer_sample(row.kind == ROW_RESTART);
            end
            prev_write = (row.kind == ROW_WRITE);
        end
        cur_typed = 1'b0;

        // Random phases: new settings while idle, then a run of samples
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle(SETTLE_CYCLES);
            pick = $urandom_range(0, 5);
            case (pick)
                0: noise_pick = 64'd0;
                1: noise_pick = 64'd2560;
                2: noise_pick = 64'($urandom_range(0, 4095));
                3: noise_pick = 64'($urandom_range(1, 300));
                default: noise_pick = {$urandom, $urandom};
            endcase
            pick = $urandom_range(0, 7);
            if (pick == 0)
                seed_pick = '0;
            else if (pick == 1)
                seed_pick = '1;
            else
                seed_pick = {$urandom, $urandom};
            reseed     = (phase_no == 0) || ($urandom_range(0, 1) == 1);
            seed_first = 1'($urandom_range(0, 1));
            if (reseed && seed_first)
                write_reg(REG_SEED_VALUE, seed_pick);
            write_reg(REG_NOISE_LEVEL, noise_pick);
            if (reseed && !seed_first)
                write_reg(REG_SEED_VALUE, seed_pick);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          {$urandom, $urandom});
            cfg_valid <= 1'b0;

            // second phase: long output hold while samples keep coming
            calm = (phase_no == 1) || ($urandom_range(0, 4) == 0);
            if (phase_no == 1)
                hold_req = 1'b1;
            phase_len = $urandom_range(30, 150);
            for (int n = 0; n < phase_len; n++)
            begin
                gap = calm ? 0 : sender_gap();
                if (gap > 0)
                begin
                    sample_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                offer_sample($urandom_range(0, 39) == 0);
                sent++;
            end
            phase_no++;
        end

        settle(DRAIN_CYCLES);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
